// ----- sv/rsv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_pkg
// Shared types and constants of the resampling sample voice.
// ----------------------------------------------------------------------------
package rsv_pkg;

   localparam int MEMORY_DEPTH   = 65536;
   localparam int FRACTION_WIDTH = 16;
   localparam int QUEUE_DEPTH    = 2;
   localparam int CSR_ADDR_WIDTH = 4;

   localparam logic [16:0]        UNITY_VOLUME   = 17'h10000;
   localparam logic [16:0]        POSITION_MAX   = 17'h1FFFF;
   localparam logic [23:0]        COUNTER_MAX    = 24'hFFFFFF;
   localparam logic signed [15:0] REPEAT_FOREVER = -16'sd1;

   localparam logic [23:0]        PHASE_INC_RESET  = 24'd65536;
   localparam logic [16:0]        SAMPLE_LEN_RESET = 17'd0;
   localparam logic signed [15:0] REPEAT_RESET     = 16'sd1;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_TICK  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_PHASE_INCREMENT = 2'd0,
      CSR_SAMPLE_LENGTH   = 2'd1,
      CSR_REPEAT_COUNT    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL1,
      ST_MUL2,
      ST_OUT
   } state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [15:0]        address;
      logic signed [7:0]  sample_byte;
      logic [23:0]        fade_samples;
      logic [16:0]        fade_step;
   } item_type;

   typedef struct packed {
      logic [23:0]        phase_increment;
      logic [16:0]        sample_length;
      logic signed [15:0] repeat_count;
   } cfg_type;

endpackage

// ----- sv/rsv_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_req_if
// Command channel of the sample voice.
// ----------------------------------------------------------------------------
interface rsv_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [15:0]       address;
   logic signed [7:0] sample_byte;
   logic [23:0]       fade_samples;
   logic [16:0]       fade_step;

   modport source (output valid, cmd, address, sample_byte, fade_samples, fade_step,
                   input ready);
   modport sink   (input valid, cmd, address, sample_byte, fade_samples, fade_step,
                   output ready);
endinterface

// ----- sv/rsv_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_rsp_if
// Sample output channel of the sample voice.
// ----------------------------------------------------------------------------
interface rsv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_out;
   logic               playing;

   modport source (output valid, sample_out, playing, input ready);
   modport sink   (input valid, sample_out, playing, output ready);
endinterface

// ----- sv/rsv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_front
// Command intake: decodes each transfer and holds it in a short queue.
// ----------------------------------------------------------------------------
module rsv_front (
   input  logic               clock,
   input  logic               reset,
   rsv_req_if.sink            req_chan,
   output rsv_pkg::item_type  head,
   output logic               head_valid,
   input  logic               pop
);

   localparam int PW = (rsv_pkg::QUEUE_DEPTH > 1) ? $clog2(rsv_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(rsv_pkg::QUEUE_DEPTH + 1);

   rsv_pkg::item_type q_mem_ff [rsv_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   rsv_pkg::item_type decoded;
   logic push;
   logic do_pop;

   assign req_chan.ready = (count_ff != CW'(rsv_pkg::QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign head_valid     = (count_ff != '0);
   assign head           = q_mem_ff[rd_ptr_ff];
   assign do_pop         = pop && head_valid;

   // a zero fade step acts as one
   always_comb begin
      decoded.cmd          = rsv_pkg::cmd_type'(req_chan.cmd);
      decoded.address      = req_chan.address;
      decoded.sample_byte  = req_chan.sample_byte;
      decoded.fade_samples = req_chan.fade_samples;
      decoded.fade_step    = (req_chan.fade_step == '0) ? 17'd1 : req_chan.fade_step;
   end

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(rsv_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PW'(1);
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ----- sv/rsv_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsv_back
// Voice engine: sample memory, phase accumulator, interpolation, fade and
// output register.
// ----------------------------------------------------------------------------
module rsv_back #(
   parameter int MEMORY_DEPTH   = rsv_pkg::MEMORY_DEPTH,
   parameter int FRACTION_WIDTH = rsv_pkg::FRACTION_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  rsv_pkg::cfg_type   cfg,
   input  rsv_pkg::item_type  head,
   input  logic               head_valid,
   output logic               pop,
   rsv_rsp_if.source          rsp_chan
);

   localparam int AW = $clog2(MEMORY_DEPTH);
   localparam int FW = FRACTION_WIDTH;
   localparam int PW = FW + 10;
   localparam logic signed [PW-1:0] ROUND = PW'(64'd1 << (FW - 1));

   logic [7:0] mem [MEMORY_DEPTH];
   logic              mem_we;
   logic              mem_re;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [7:0]        rd_data_ff;

   rsv_pkg::state_type state_ff, state_in;
   logic [16:0]        pos_ff, pos_in;
   logic [FW-1:0]      frac_ff, frac_in;
   logic signed [7:0]  cur_ff, cur_in;
   logic signed [7:0]  prev_ff, prev_in;
   logic signed [15:0] rep_ff, rep_in;
   logic [16:0]        vol_ff, vol_in;
   logic [23:0]        cnt_ff, cnt_in;
   logic [23:0]        flen_ff, flen_in;
   logic [16:0]        fstep_ff, fstep_in;
   logic               fout_ff, fout_in;
   logic               fading_ff, fading_in;
   logic               ended_ff, ended_in;
   logic               adv_ff, adv_in;
   logic               silent_ff, silent_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [27:0] scaled_ff, scaled_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_playing_ff, rsp_playing_in;

   logic signed [8:0]    diff;
   logic signed [PW-1:0] frac_s;
   logic [FW:0]          frac_sum;
   logic [18:0]          npos;
   logic [16:0]          pos_sat;
   logic signed [9:0]    quot;
   logic signed [9:0]    interp;
   logic signed [17:0]   vol_s;
   logic [23:0]          cnt_next;
   logic [17:0]          vol_sub;
   logic [17:0]          vol_add;
   logic                 out_free;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_sample_ff;
   assign rsp_chan.playing    = rsp_playing_ff;
   assign out_free            = !rsp_valid_ff || rsp_chan.ready;

   // datapath terms
   always_comb begin
      diff     = 9'(cur_ff) - 9'(prev_ff);
      frac_s   = $signed(PW'({1'b0, frac_ff}));
      frac_sum = {1'b0, frac_ff} + {1'b0, FW'(cfg.phase_increment)};
      npos     = 19'(pos_ff) + 19'(cfg.phase_increment >> FW) + 19'(frac_sum[FW]);
      pos_sat  = (npos > 19'(rsv_pkg::POSITION_MAX)) ? rsv_pkg::POSITION_MAX : npos[16:0];
      quot     = $signed(10'(prod_ff >>> FW));
      interp   = 10'(prev_ff) + quot;
      vol_s    = $signed({1'b0, vol_ff});
      cnt_next = (cnt_ff != rsv_pkg::COUNTER_MAX) ? cnt_ff + 24'd1 : cnt_ff;
      vol_sub  = {1'b0, vol_ff} - {1'b0, fstep_ff};
      vol_add  = {1'b0, vol_ff} + {1'b0, fstep_ff};
   end

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      frac_in        = frac_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      rep_in         = rep_ff;
      vol_in         = vol_ff;
      cnt_in         = cnt_ff;
      flen_in        = flen_ff;
      fstep_in       = fstep_ff;
      fout_in        = fout_ff;
      fading_in      = fading_ff;
      ended_in       = ended_ff;
      adv_in         = adv_ff;
      silent_in      = silent_ff;
      prod_in        = prod_ff;
      scaled_in      = scaled_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_playing_in = rsp_playing_ff;
      pop            = 1'b0;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      wr_addr        = AW'(head.address);
      rd_addr        = '0;

      unique case (state_ff)
         rsv_pkg::ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               unique case (head.cmd)
                  rsv_pkg::CMD_WRITE: begin
                     mem_we = 1'b1;
                  end
                  rsv_pkg::CMD_START: begin
                     if (ended_ff) begin
                        rep_in   = cfg.repeat_count;
                        ended_in = 1'b0;
                        pos_in   = '0;
                        frac_in  = '0;
                        cnt_in   = '0;
                        mem_re   = 1'b1;
                        state_in = rsv_pkg::ST_LOAD;
                        if (head.fade_samples == '0) begin
                           fading_in = 1'b0;
                           vol_in    = rsv_pkg::UNITY_VOLUME;
                           flen_in   = '0;
                           fout_in   = 1'b0;
                           fstep_in  = '0;
                        end else begin
                           fading_in = 1'b1;
                           vol_in    = '0;
                           flen_in   = head.fade_samples;
                           fout_in   = 1'b0;
                           fstep_in  = head.fade_step;
                        end
                     end
                  end
                  rsv_pkg::CMD_STOP: begin
                     if (head.fade_samples == '0) begin
                        ended_in = 1'b1;
                     end else begin
                        fading_in = 1'b1;
                        vol_in    = rsv_pkg::UNITY_VOLUME;
                        flen_in   = head.fade_samples;
                        fout_in   = 1'b1;
                        fstep_in  = head.fade_step;
                        cnt_in    = '0;
                     end
                  end
                  rsv_pkg::CMD_TICK: begin
                     // end of sample: rewind or end
                     if (!ended_ff && (pos_ff >= cfg.sample_length)) begin
                        if ((rep_ff == rsv_pkg::REPEAT_FOREVER) || (rep_ff > 16'sd1)) begin
                           if (rep_ff != rsv_pkg::REPEAT_FOREVER) begin
                              rep_in = rep_ff - 16'sd1;
                           end
                           pos_in  = '0;
                           frac_in = '0;
                        end else begin
                           ended_in = 1'b1;
                        end
                     end
                     state_in = rsv_pkg::ST_MUL1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         rsv_pkg::ST_LOAD: begin
            prev_in  = cur_ff;
            cur_in   = $signed(rd_data_ff);
            state_in = rsv_pkg::ST_IDLE;
         end
         rsv_pkg::ST_MUL1: begin
            if (ended_ff) begin
               silent_in = 1'b1;
               state_in  = rsv_pkg::ST_OUT;
            end else begin
               silent_in = 1'b0;
               prod_in   = PW'(diff) * frac_s + ROUND;
               pos_in    = pos_sat;
               frac_in   = frac_sum[FW-1:0];
               adv_in    = (pos_sat > pos_ff);
               mem_re    = 1'b1;
               rd_addr   = AW'(pos_ff);
               state_in  = rsv_pkg::ST_MUL2;
            end
         end
         rsv_pkg::ST_MUL2: begin
            scaled_in = 28'(interp) * 28'(vol_s);
            state_in  = rsv_pkg::ST_OUT;
         end
         rsv_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_playing_in = !silent_ff;
               rsp_sample_in  = silent_ff ? 16'sd0 : $signed(scaled_ff[23:8]);
               state_in       = rsv_pkg::ST_IDLE;
               if (!silent_ff) begin
                  if (adv_ff) begin
                     prev_in = cur_ff;
                     cur_in  = $signed(rd_data_ff);
                  end
                  if (fading_ff) begin
                     cnt_in = cnt_next;
                     if (cnt_next >= flen_ff) begin
                        if (fout_ff) begin
                           ended_in = 1'b1;
                        end else begin
                           vol_in    = rsv_pkg::UNITY_VOLUME;
                           fading_in = 1'b0;
                        end
                     end else if (fout_ff) begin
                        vol_in = vol_sub[17] ? 17'd0 : vol_sub[16:0];
                     end else begin
                        vol_in = (vol_add > 18'(rsv_pkg::UNITY_VOLUME)) ?
                                 rsv_pkg::UNITY_VOLUME : vol_add[16:0];
                     end
                  end
               end
            end
         end
         default: begin
            state_in = rsv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rsv_pkg::ST_IDLE;
         pos_ff         <= '0;
         frac_ff        <= '0;
         cur_ff         <= '0;
         prev_ff        <= '0;
         rep_ff         <= '0;
         vol_ff         <= rsv_pkg::UNITY_VOLUME;
         cnt_ff         <= '0;
         flen_ff        <= '0;
         fstep_ff       <= '0;
         fout_ff        <= 1'b0;
         fading_ff      <= 1'b0;
         ended_ff       <= 1'b1;
         adv_ff         <= 1'b0;
         silent_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         frac_ff        <= frac_in;
         cur_ff         <= cur_in;
         prev_ff        <= prev_in;
         rep_ff         <= rep_in;
         vol_ff         <= vol_in;
         cnt_ff         <= cnt_in;
         flen_ff        <= flen_in;
         fstep_ff       <= fstep_in;
         fout_ff        <= fout_in;
         fading_ff      <= fading_in;
         ended_ff       <= ended_in;
         adv_ff         <= adv_in;
         silent_ff      <= silent_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff        <= prod_in;
      scaled_ff      <= scaled_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_playing_ff <= rsp_playing_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= head.sample_byte;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- sv/resampling_sample_voice.sv -----
`timescale 1ns / 1ps
// A tick goes from the queue head through MUL1, MUL2 and OUT to the output register;
// when ended it skips MUL2, and OUT waits while the output register is still full.
// A byte write or stop is handled in IDLE, a start also passes LOAD. The engine pops
// no command outside IDLE; a two-entry command queue lets commands arrive meanwhile.
// Reset is synchronous and active high: voice ended, registers at defaults,
// sample memory is not cleared.
// ----------------------------------------------------------------------------
// resampling_sample_voice
// Single-voice 8-bit sample player with linear interpolation and fades.
// ----------------------------------------------------------------------------
module resampling_sample_voice #(
   parameter int MEMORY_DEPTH   = rsv_pkg::MEMORY_DEPTH,
   parameter int FRACTION_WIDTH = rsv_pkg::FRACTION_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   rsv_req_if.sink                            req_chan,
   rsv_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rsv_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   rsv_pkg::cfg_type  cfg_ff, cfg_in;
   rsv_pkg::item_type head;
   logic              head_valid;
   logic              pop;
   logic              csr_write;
   rsv_pkg::csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = rsv_pkg::csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      unique case (csr_index)
         rsv_pkg::CSR_PHASE_INCREMENT: begin
            csr_prdata = 32'(cfg_ff.phase_increment);
            if (csr_write) begin
               cfg_in.phase_increment = csr_pwdata[23:0];
            end
         end
         rsv_pkg::CSR_SAMPLE_LENGTH: begin
            csr_prdata = 32'(cfg_ff.sample_length);
            if (csr_write) begin
               cfg_in.sample_length = csr_pwdata[16:0];
            end
         end
         rsv_pkg::CSR_REPEAT_COUNT: begin
            csr_prdata = 32'(cfg_ff.repeat_count);
            if (csr_write) begin
               cfg_in.repeat_count = $signed(csr_pwdata[15:0]);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_increment <= rsv_pkg::PHASE_INC_RESET;
         cfg_ff.sample_length   <= rsv_pkg::SAMPLE_LEN_RESET;
         cfg_ff.repeat_count    <= rsv_pkg::REPEAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rsv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop)
   );

   rsv_back #(
      .MEMORY_DEPTH   (MEMORY_DEPTH),
      .FRACTION_WIDTH (FRACTION_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the resampling sample voice. A scoreboard class
// keeps its own model of the voice: sample memory, phase, fade and repeat
// state. From each accepted command it predicts the output sample of every
// tick and checks the result channel in order. Directed commands cover the
// corner cases. Random phases then load new register settings, write a
// short sample, start the voice and run mostly ticks, mixed with stops,
// restarts and stray writes. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import rsv_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER = 300;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               playing;
   } voice_result_type;

   class voice_scoreboard;
      voice_result_type  expected_samples[$];
      logic signed [7:0] sample_memory [MEMORY_DEPTH];
      bit                written [MEMORY_DEPTH];
      logic [23:0]        phase_increment;
      logic [16:0]        sample_length;
      logic signed [15:0] repeat_count;
      logic [16:0]        position;
      logic [15:0]        position_fraction;
      logic signed [7:0]  current_value;
      logic signed [7:0]  previous_value;
      logic signed [15:0] repeats_left;
      logic [16:0]        fade_volume;
      logic [23:0]        fade_counter;
      logic [23:0]        fade_length;
      logic signed [17:0] fade_delta;
      bit                 fading;
      bit                 ended;
      int                 errors;
      int                 checked;

      function new();
         phase_increment   = PHASE_INC_RESET;
         sample_length     = SAMPLE_LEN_RESET;
         repeat_count      = REPEAT_RESET;
         position          = '0;
         position_fraction = '0;
         current_value     = '0;
         previous_value    = '0;
         repeats_left      = '0;
         fade_volume       = UNITY_VOLUME;
         fade_counter      = '0;
         fade_length       = '0;
         fade_delta        = '0;
         fading            = 0;
         ended             = 1;
         errors            = 0;
         checked           = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_PHASE_INCREMENT: phase_increment = value[23:0];
            CSR_SAMPLE_LENGTH:   sample_length   = value[16:0];
            CSR_REPEAT_COUNT:    repeat_count    = value[15:0];
            default: ;
         endcase
      endfunction

      // Would the next tick fetch a byte that was never written?
      function bit tick_reads_unwritten(output logic [15:0] addr);
         logic [16:0] pos;
         logic [15:0] frac;
         int          tmp;
         int          npos;
         addr = '0;
         if (ended) return 0;
         pos  = position;
         frac = position_fraction;
         if (pos >= sample_length) begin
            if (repeats_left == REPEAT_FOREVER || repeats_left > 1) begin
               pos  = '0;
               frac = '0;
            end else begin
               return 0;
            end
         end
         tmp  = int'(frac) + int'(phase_increment[15:0]);
         npos = int'(pos) + int'(phase_increment[23:16]) + (tmp >> FRACTION_WIDTH);
         if (npos > int'(POSITION_MAX)) npos = int'(POSITION_MAX);
         addr = pos[15:0];
         return (int'(pos) < npos) && !written[addr];
      endfunction

      function void note_input(item_type it);
         logic [16:0]      step;
         logic [16:0]      old;
         longint           diff;
         longint           interp;
         longint           scaled;
         int               tmp;
         int               npos;
         int               vol;
         voice_result_type r;
         step = (it.fade_step == 0) ? 17'd1 : it.fade_step;
         case (it.cmd)
            CMD_WRITE: begin
               sample_memory[it.address] = it.sample_byte;
               written[it.address] = 1;
            end
            CMD_START: begin
               if (ended) begin
                  repeats_left      = repeat_count;
                  ended             = 0;
                  position          = '0;
                  position_fraction = '0;
                  previous_value    = current_value;
                  current_value     = sample_memory[0];
                  fade_counter      = '0;
                  if (it.fade_samples == 0) begin
                     fading      = 0;
                     fade_volume = UNITY_VOLUME;
                     fade_length = '0;
                     fade_delta  = '0;
                  end else begin
                     fading      = 1;
                     fade_volume = '0;
                     fade_length = it.fade_samples;
                     fade_delta  = -$signed({1'b0, step});
                  end
               end
            end
            CMD_STOP: begin
               if (it.fade_samples == 0) begin
                  ended = 1;
               end else begin
                  fading       = 1;
                  fade_volume  = UNITY_VOLUME;
                  fade_length  = it.fade_samples;
                  fade_delta   = $signed({1'b0, step});
                  fade_counter = '0;
               end
            end
            CMD_TICK: begin
               if (!ended && position >= sample_length) begin
                  if (repeats_left == REPEAT_FOREVER || repeats_left > 1) begin
                     if (repeats_left != REPEAT_FOREVER) repeats_left = repeats_left - 16'sd1;
                     position          = '0;
                     position_fraction = '0;
                  end else begin
                     ended = 1;
                  end
               end
               if (ended) begin
                  r.sample_out = '0;
                  r.playing    = 0;
                  expected_samples.push_back(r);
                  return;
               end
               diff   = longint'(current_value) - longint'(previous_value);
               interp = longint'(previous_value) +
                        ((diff * longint'(position_fraction) + longint'(32768))
                         >>> FRACTION_WIDTH);
               scaled = (interp * 256 * longint'(fade_volume)) >>> 16;
               r.sample_out = scaled[15:0];
               r.playing    = 1;
               expected_samples.push_back(r);

               old  = position;
               tmp  = int'(position_fraction) + int'(phase_increment[15:0]);
               npos = int'(position) + int'(phase_increment[23:16]) + (tmp >> FRACTION_WIDTH);
               position = (npos > int'(POSITION_MAX)) ? POSITION_MAX : npos[16:0];
               position_fraction = tmp[15:0];
               if (old < position) begin
                  previous_value = current_value;
                  current_value  = sample_memory[old[15:0]];
               end

               if (fading) begin
                  if (fade_counter < COUNTER_MAX) fade_counter = fade_counter + 24'd1;
                  if (fade_counter >= fade_length) begin
                     if (fade_delta > 0) begin
                        ended = 1;
                     end else begin
                        fade_volume = UNITY_VOLUME;
                        fading      = 0;
                     end
                  end else begin
                     vol = int'(fade_volume) - int'(fade_delta);
                     if (vol < 0) vol = 0;
                     if (vol > int'(UNITY_VOLUME)) vol = int'(UNITY_VOLUME);
                     fade_volume = vol[16:0];
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_output(logic signed [15:0] sample_out, logic playing);
         voice_result_type e;
         checked++;
         if (expected_samples.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer, sample_out %0d playing %0d",
                     $time, sample_out, playing);
            return;
         end
         e = expected_samples.pop_front();
         if (sample_out !== e.sample_out) begin
            errors++;
            $display("%0t: sample_out expected %0d actual %0d",
                     $time, e.sample_out, sample_out);
         end
         if (playing !== e.playing) begin
            errors++;
            $display("%0t: playing expected %0d actual %0d", $time, e.playing, playing);
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rsv_req_if req_if ();
   rsv_rsp_if rsp_if ();

   voice_scoreboard sb;
   bit pace_off;
   bit hold_done;
   int cycle_count;

   resampling_sample_voice dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int draw_gap();
      return pace_off ? 0 : int'($urandom_range(0, 5));
   endfunction

   function automatic item_type random_item(cmd_type c);
      item_type it;
      it.cmd          = c;
      it.address      = 16'($urandom());
      it.sample_byte  = 8'($urandom());
      it.fade_samples = 24'($urandom());
      it.fade_step    = 17'($urandom_range(1, 65536));
      return it;
   endfunction

   function automatic void pick_fade(output logic [23:0] len, output logic [16:0] step);
      int s;
      s = $urandom_range(0, 9);
      if (s < 5) begin
         len = '0;
      end else if (s < 8) begin
         len = 24'($urandom_range(1, 64));
      end else begin
         len = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'($urandom());
      end
      if (len == 0) len = (s >= 5) ? 24'd1 : 24'd0;
      step = (len >= 65536 || len == 0) ? 17'd1 : 17'(65536 / len);
      if (s == 9) step = 17'($urandom_range(0, 65536));
   endfunction

   // Entered just after a posedge, leaves just after the posedge of the transfer.
   task automatic send_item(item_type it);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.cmd          <= it.cmd;
      req_if.address      <= it.address;
      req_if.sample_byte  <= it.sample_byte;
      req_if.fade_samples <= it.fade_samples;
      req_if.fade_step    <= it.fade_step;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_input(it);
   endtask

   task automatic write_byte(logic [15:0] addr, logic signed [7:0] value);
      item_type it;
      it = random_item(CMD_WRITE);
      it.address     = addr;
      it.sample_byte = value;
      send_item(it);
   endtask

   task automatic send_tick();
      logic [15:0] addr;
      while (sb.tick_reads_unwritten(addr)) write_byte(addr, 8'($urandom()));
      send_item(random_item(CMD_TICK));
   endtask

   task automatic send_fade_cmd(cmd_type c, logic [23:0] len, logic [16:0] step);
      item_type it;
      it = random_item(c);
      it.fade_samples = len;
      it.fade_step    = step;
      send_item(it);
   endtask

   task automatic send_random_fade_cmd(cmd_type c);
      logic [23:0] len;
      logic [16:0] step;
      pick_fade(len, step);
      send_fade_cmd(c, len, step);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Stop offering, let every pending result drain and the queue settle.
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int stall;
         stall = draw_gap();
         if (!hold_done && sb.checked >= HOLD_AFTER) begin
            stall     = HOLD_CYCLES;
            hold_done = 1;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         sb.check_output(rsp_if.sample_out, rsp_if.playing);
         @(negedge clock);
      end
   end

   initial begin
      int          len;
      int          r;
      logic [23:0] inc;
      logic [16:0] slen;
      logic [15:0] rep;
      sb                  = new();
      cycle_count         = 0;
      pace_off            = 0;
      hold_done           = 0;
      reset               = 1'b1;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      req_if.valid        = 1'b0;
      req_if.cmd          = CMD_WRITE;
      req_if.address      = '0;
      req_if.sample_byte  = '0;
      req_if.fade_samples = '0;
      req_if.fade_step    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corner cases
      csr_write(CSR_PHASE_INCREMENT, 32'h8000);
      csr_write(CSR_SAMPLE_LENGTH, 32'd3);
      csr_write(CSR_REPEAT_COUNT, 32'd2);
      @(posedge clock);
      write_byte(16'd0, -8'sd128);
      write_byte(16'd1, 8'sd127);
      write_byte(16'd2, 8'sd0);
      write_byte(16'hFFFF, 8'sd127);
      send_tick();                                   // ended after reset
      send_fade_cmd(CMD_STOP, 24'd5, 17'd13107);     // stop while ended, with fade
      send_tick();
      send_fade_cmd(CMD_STOP, 24'd0, 17'd1);         // stop while ended, no fade
      send_fade_cmd(CMD_START, 24'd3, 17'd0);        // fade step zero
      repeat (7) send_tick();                        // fade-in, rewind with repeats
      send_fade_cmd(CMD_START, 24'd0, 17'd1);        // start while playing
      send_fade_cmd(CMD_STOP, 24'd2, 17'd32768);     // fade-out to end
      repeat (3) send_tick();
      send_fade_cmd(CMD_START, 24'd0, 17'd1);
      send_tick();
      send_fade_cmd(CMD_STOP, 24'd1, 17'd65536);
      repeat (2) send_tick();

      // random phases
      for (int phase = 0; phase < 10; phase++) begin
         wait_idle();
         pace_off = (phase % 4 == 2);
         case (phase % 5)
            0: inc = 24'd65536;
            1: inc = 24'd0;
            2: inc = 24'hFFFFFF;
            3: inc = 24'($urandom_range(24'h2000, 24'h30000));
            default: inc = 24'($urandom());
         endcase
         case (phase % 4)
            1: slen = 17'd0;
            2: slen = 17'd65536;
            default: slen = 17'($urandom_range(1, 40));
         endcase
         case (phase % 6)
            0: rep = 16'd1;
            1: rep = REPEAT_FOREVER;
            2: rep = 16'($urandom_range(2, 4));
            3: rep = 16'd0;
            4: rep = 16'd32767;
            default: rep = 16'($urandom());
         endcase
         csr_write(CSR_PHASE_INCREMENT, {8'd0, inc});
         csr_write(CSR_SAMPLE_LENGTH, {15'd0, slen});
         csr_write(CSR_REPEAT_COUNT, {16'd0, rep});
         @(posedge clock);
         len = (slen > 40) ? 40 : int'(slen);
         for (int a = 0; a < len; a++) write_byte(a[15:0], 8'($urandom()));
         send_random_fade_cmd(CMD_START);
         repeat (110) begin
            r = $urandom_range(0, 99);
            if (sb.ended && r < 25) send_random_fade_cmd(CMD_START);
            else if (r < 80) send_tick();
            else if (r < 86) send_random_fade_cmd(CMD_STOP);
            else if (r < 90) send_random_fade_cmd(CMD_START);
            else send_item(random_item(CMD_WRITE));
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
